>>> rtl/core/hnm_pkg.sv
package hnm_pkg;

    localparam int S_W   = 19;
    localparam int LQ_W  = 18;
    localparam int DEN_W = LQ_W + 1;
    localparam int NUM_W = 27;
    localparam int Q_W   = 8;

    localparam logic [S_W-1:0] SUM_BIAS = 19'd260100;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic FN_SAMPLE = 1'b0;
    localparam logic FN_FLUSH  = 1'b1;

    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // 255 * t, where t = 256 * v + Lq is never negative for valid inputs.
    function automatic logic [NUM_W-1:0] bias_num(input logic signed [20:0] t);
        logic signed [28:0] prod;
        prod = {t, 8'b0} - {{8{t[20]}}, t};
        bias_num = prod[28] ? '0 : prod[NUM_W-1:0];
    endfunction

endpackage

>>> rtl/core/hnm_line_store.sv
module hnm_line_store
    import hnm_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/hnm_isqrt.sv
module hnm_isqrt
    import hnm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [S_W-1:0]  radicand,
    output logic            done,
    output logic [LQ_W-1:0] root
);

    // Radicand is S * 65536; one result bit is resolved per cycle.
    logic [34:0] n_reg;
    logic [35:0] root_reg;
    logic [34:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] trial;

    assign trial = root_reg + {1'b0, bit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= {radicand, 16'b0};
            root_reg <= '0;
            bit_reg  <= 35'(1) << 34;
        end
        else if (busy_reg)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_reg    <= n_reg - trial[34:0];
                root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[LQ_W-1:0];

endmodule

>>> rtl/core/hnm_bias_div.sv
module hnm_bias_div
    import hnm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    // The numerator is always below 256 times the divisor, so eight
    // restoring steps give the whole quotient.
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsr_reg;
    logic [Q_W-1:0]   q_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd7);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsr_reg <= {1'b0, den, 7'b0};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_reg <= rem_reg - dsr_reg;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[Q_W-2:0], 1'b0};
            end
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/core/heightmap_to_normal_map.sv
// Height map to normal map converter.
// Input channel (in_valid / in_stall): func = 0 carries one height sample in
// raster order, func = 1 drains one pending result of the last row. Output
// channel (out_valid / out_stall): one biased normal per beat, last_of_image
// marks the final pixel. Results for row y appear while row y + 1 streams in.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets image width
// and height; a write restarts the image. Write only while the block is idle.
// One item is worked on at a time. A sample with a result passes through two
// line store reads (three for a flush), the square root and the divider set;
// a sample with no result stops after its line store write.
// A finished result sits in the output register; the block takes the next
// item while it waits, and holds it there unchanged while out_stall is high.
// A second finished result waits inside and stalls the input until it moves.
// Reset clears all counters and the output valid flag; line stores keep
// whatever they hold, and each entry that feeds a result is written first.
module heightmap_to_normal_map
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  height_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  normal_x,
    output logic [7:0]  normal_y,
    output logic [7:0]  normal_z,
    output logic        last_of_image,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_CALC = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_NUM  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [AW:0] width_reg;
    logic [12:0] height_reg;
    logic [AW-1:0] col_reg, fcol_reg;
    logic [11:0] row_reg;
    logic        draining_reg;
    logic [7:0]  prev_reg;

    logic [AW-1:0] x_reg;
    logic [7:0]  s_reg;
    logic        flush_reg, emit_reg, own_down_reg, left_edge_reg, right_edge_reg, last_reg;
    logic [7:0]  c_reg, d_reg, u_reg, l_reg, r_reg;
    logic signed [8:0] dx_reg, dz_reg;

    logic        out_valid_reg;
    logic [7:0]  nx_reg, ny_reg, nz_reg;
    logic        nlast_reg;

    logic          accept;
    logic          is_flush;
    logic          take_sample, take_flush;
    logic [AW-1:0] x_in;
    logic          last_col;
    logic [AW-1:0] rd_addr_b;
    logic [7:0]    rdata_a, rdata_b;
    logic          mem_we;
    logic [31:0]   w_clamp;
    logic [12:0]   h_clamp;

    logic signed [8:0]  dx_c, dz_c;
    logic signed [17:0] sqx, sqz;
    logic [S_W-1:0]     sum_c;
    logic               sq_done;
    logic [LQ_W-1:0]    lq;
    logic [NUM_W-1:0]   num_x, num_y, num_z;
    logic [DEN_W-1:0]   den;
    logic               div_start;
    logic               dvx_done, dvy_done, dvz_done;
    logic [Q_W-1:0]     qx, qy, qz;
    logic               out_load;

    assign accept      = in_valid && !in_stall;
    assign is_flush    = (func == FN_FLUSH);
    assign take_sample = accept && !is_flush && !draining_reg;
    assign take_flush  = accept && is_flush && draining_reg;
    assign x_in        = is_flush ? fcol_reg : col_reg;
    assign last_col    = ({1'b0, x_in} + (AW + 1)'(1)) >= width_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data == 13'd0)
        begin
            w_clamp = 32'd1;
        end
        else if ({19'b0, cfg_data} > 32'(MAX_WIDTH))
        begin
            w_clamp = 32'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = {19'b0, cfg_data};
        end
        if (cfg_data == 13'd0)
        begin
            h_clamp = 13'd1;
        end
        else if (cfg_data > MAX_HEIGHT)
        begin
            h_clamp = MAX_HEIGHT;
        end
        else
        begin
            h_clamp = cfg_data;
        end
    end

    // Position counters advance when an item is taken and clear on a configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= (AW + 1)'(MAX_WIDTH);
            height_reg   <= MAX_HEIGHT;
            col_reg      <= '0;
            row_reg      <= '0;
            fcol_reg     <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            if (take_sample)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    if (({1'b0, row_reg} + 13'd1) >= height_reg)
                    begin
                        row_reg      <= '0;
                        fcol_reg     <= '0;
                        draining_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg <= row_reg + 12'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + AW'(1);
                end
            end
            else if (take_flush)
            begin
                if (last_col)
                begin
                    fcol_reg     <= '0;
                    draining_reg <= 1'b0;
                end
                else
                begin
                    fcol_reg <= fcol_reg + AW'(1);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= (AW + 1)'(w_clamp);
                    REG_IMAGE_HEIGHT: height_reg <= h_clamp;
                    default:          width_reg  <= width_reg;
                endcase
                col_reg      <= '0;
                row_reg      <= '0;
                fcol_reg     <= '0;
                draining_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (state_reg == S_RD0 && !flush_reg)
        begin
            prev_reg <= rdata_b;
        end
    end

    // Item context and neighbourhood registers.
    always_ff @(posedge clk)
    begin
        if (take_sample || take_flush)
        begin
            x_reg          <= x_in;
            s_reg          <= height_sample;
            flush_reg      <= is_flush;
            emit_reg       <= is_flush || (row_reg != 12'd0);
            own_down_reg   <= is_flush ? (height_reg <= 13'd1) : (row_reg <= 12'd1);
            left_edge_reg  <= (x_in == '0);
            right_edge_reg <= last_col;
            last_reg       <= is_flush && last_col;
        end
        case (state_reg)
            S_RD0:
            begin
                c_reg <= rdata_b;
                d_reg <= own_down_reg ? rdata_b : rdata_a;
                u_reg <= flush_reg ? rdata_b : s_reg;
                l_reg <= left_edge_reg ? rdata_b : prev_reg;
            end
            S_RD1:
            begin
                r_reg <= right_edge_reg ? c_reg : rdata_b;
            end
            S_RD2:
            begin
                l_reg <= left_edge_reg ? c_reg : rdata_b;
            end
            S_CALC:
            begin
                dx_reg <= dx_c;
                dz_reg <= dz_c;
            end
            default:
            begin
                c_reg <= c_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_RD0:   rd_addr_b = x_reg + AW'(1);
            S_RD1:   rd_addr_b = x_reg - AW'(1);
            default: rd_addr_b = x_in;
        endcase
    end

    assign mem_we = (state_reg == S_RD0) && !flush_reg;

    // Store a holds the row before last, store b the most recent row.
    hnm_line_store #(.DEPTH(MAX_WIDTH)) u_store_a
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (x_reg),
        .wdata (rdata_b),
        .raddr (x_in),
        .rdata (rdata_a)
    );

    hnm_line_store #(.DEPTH(MAX_WIDTH)) u_store_b
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (x_reg),
        .wdata (s_reg),
        .raddr (rd_addr_b),
        .rdata (rdata_b)
    );

    assign dx_c  = $signed({1'b0, l_reg}) - $signed({1'b0, r_reg});
    assign dz_c  = $signed({1'b0, d_reg}) - $signed({1'b0, u_reg});
    assign sqx   = dx_c * dx_c;
    assign sqz   = dz_c * dz_c;
    assign sum_c = S_W'(sqx[16:0]) + S_W'(sqz[16:0]) + SUM_BIAS;

    hnm_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_CALC),
        .radicand (sum_c),
        .done     (sq_done),
        .root     (lq)
    );

    assign div_start = (state_reg == S_NUM);
    assign den       = {lq, 1'b0};
    assign num_x     = bias_num($signed({{4{dx_reg[8]}}, dx_reg, 8'b0}) +
                                $signed({3'b0, lq}));
    assign num_y     = bias_num($signed(21'd130560) + $signed({3'b0, lq}));
    assign num_z     = bias_num($signed({{4{dz_reg[8]}}, dz_reg, 8'b0}) +
                                $signed({3'b0, lq}));

    hnm_bias_div u_div_x
    (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num (num_x), .den (den), .done (dvx_done), .quot (qx)
    );

    hnm_bias_div u_div_y
    (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num (num_y), .den (den), .done (dvy_done), .quot (qy)
    );

    hnm_bias_div u_div_z
    (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .num (num_z), .den (den), .done (dvz_done), .quot (qz)
    );

    logic [Q_W-1:0] qx_reg, qy_reg, qz_reg;

    always_ff @(posedge clk)
    begin
        if (dvx_done && dvy_done && dvz_done)
        begin
            qx_reg <= qx;
            qy_reg <= qy;
            qz_reg <= qz;
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (take_sample || take_flush) state_next = S_RD0;
            S_RD0:  state_next = emit_reg ? S_RD1 : S_IDLE;
            S_RD1:  state_next = flush_reg ? S_RD2 : S_CALC;
            S_RD2:  state_next = S_CALC;
            S_CALC: state_next = S_SQRT;
            S_SQRT: if (sq_done) state_next = S_NUM;
            S_NUM:  state_next = S_DIV;
            S_DIV:  if (dvx_done) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            nx_reg    <= qx_reg;
            ny_reg    <= qy_reg;
            nz_reg    <= qz_reg;
            nlast_reg <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign normal_x      = nx_reg;
    assign normal_y      = ny_reg;
    assign normal_z      = nz_reg;
    assign last_of_image = nlast_reg;

    a_write_in_rd0: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_RD0))
        else $error("line store written outside the read phase");

    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_SQRT))
        else $error("square root finished while not awaited");

    a_drain_col: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (col_reg == '0))
        else $error("column counter moved during drain");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output state");

endmodule
